### rtl/btm_pkg.sv
// shared types and widths for the butterfly tile map core
// no dependencies; imported by butterfly_tile_map_core
package btm_pkg;

   localparam int ORDER_W    = 16;
   localparam int SIZE_W     = 11;
   localparam int OFFSET_W   = 21;
   localparam int HALF_W     = ORDER_W - 1;
   localparam int PROD_W     = 2 * SIZE_W;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes on the csr port
   localparam logic [1:0] REG_MATRIX_ORDER = 2'd0;
   localparam logic [1:0] REG_TILE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_TILE_WIDTH   = 2'd2;

   typedef struct packed {
      logic [ORDER_W-1:0] row_index;
      logic [ORDER_W-1:0] col_index;
   } btm_req_type;

   typedef struct packed {
      logic [ORDER_W-1:0]  host_row;
      logic [ORDER_W-1:0]  host_col;
      logic [SIZE_W-1:0]   part_height;
      logic [SIZE_W-1:0]   part_width;
      logic [OFFSET_W-1:0] elem_offset;
   } btm_rsp_type;

   // per-axis constants derived from the configuration
   typedef struct packed {
      logic [SIZE_W-1:0]  tsz;
      logic [SIZE_W-1:0]  t4;
      logic [SIZE_W-1:0]  t1;
      logic [SIZE_W-1:0]  cln;
      logic [HALF_W-1:0]  fa;
      logic [ORDER_W-1:0] fb;
      logic [ORDER_W:0]   fb2p1;
      logic [ORDER_W-1:0] last;
      logic               fb_gt;
   } btm_axis_type;

   // first-stage decode of one index
   typedef struct packed {
      logic [ORDER_W-1:0] idx;
      logic [ORDER_W-1:0] i2;
      logic               lt;
      logic               mid;
      logic               tail;
   } btm_pre_type;

   // selected host index, part size and offset on one axis
   typedef struct packed {
      logic [ORDER_W-1:0] host;
      logic [SIZE_W-1:0]  size;
      logic [SIZE_W-1:0]  off;
   } btm_part_type;

endpackage

### rtl/butterfly_tile_map_core.sv
// butterfly tile map core: maps a butterfly tile index pair onto its host tile
// depends on btm_pkg (types, widths, register indexes)

// Takes one request per cycle while req_ready is high and returns its result
// through the decode, select, multiply and add stages. A result that waits at the
// output holds every stage in place and keeps req_ready low until it is taken.
// The split constants (half order divided by tile height and width) come from two
// restoring dividers that share one step counter; they run after reset and after
// every register write (load, 15 quotient bits, finish), and req_ready stays low
// until they are done. The user must write registers only with no request in
// flight; the core does not enforce this. A tile size register of 0 acts as 1.
module butterfly_tile_map_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  btm_pkg::btm_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output btm_pkg::btm_rsp_type                rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [btm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [btm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [btm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import btm_pkg::*;

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_DIV   = 2'd1;
   localparam logic [1:0] ST_FIN   = 2'd2;
   localparam logic [1:0] ST_READY = 2'd3;
   localparam int CNT_W = $clog2(HALF_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HALF_W - 1);

   // ---------------------------------------------------------------- helpers
   function automatic logic [SIZE_W-1:0] cleanup(input logic [SIZE_W-1:0] t4,
                                                 input logic [SIZE_W-1:0] t1);
      logic [SIZE_W-1:0] c;
      if (t4 < t1) c = t4;
      else if (t4 == t1) c = '0;
      else c = t4 - t1;
      return c;
   endfunction

   // key decides the doubled count and the extra tile (t4 on rows, cleanup on columns)
   function automatic btm_axis_type make_axis(input logic [SIZE_W-1:0] tsz,
                                              input logic [SIZE_W-1:0] rem,
                                              input logic [HALF_W-1:0] quo,
                                              input logic [SIZE_W-1:0] cln,
                                              input logic [SIZE_W-1:0] key,
                                              input logic              np0);
      btm_axis_type a;
      logic [ORDER_W-1:0] two_fa;
      logic [ORDER_W-1:0] base;
      a.tsz   = tsz;
      a.t4    = rem;
      a.t1    = tsz - rem;
      a.cln   = cln;
      a.fa    = quo;
      two_fa  = {quo, 1'b0};
      base    = (key == '0) ? {1'b0, quo} : two_fa;
      a.fb    = base + ORDER_W'(key >= a.t1);
      a.fb2p1 = {a.fb, 1'b1};
      a.fb_gt = a.fb > two_fa;
      // order / tsz from half / tsz: 2q plus one more when 2r + lsb reaches tsz
      a.last  = {quo, ({rem, np0} >= {1'b0, tsz})};
      return a;
   endfunction

   function automatic btm_pre_type axis_pre(input logic [ORDER_W-1:0] idx,
                                            input btm_axis_type a);
      btm_pre_type p;
      logic cln_nz;
      cln_nz = (a.cln != '0);
      p.idx  = idx;
      p.i2   = cln_nz ? idx - ORDER_W'(1) : idx;
      p.lt   = idx < a.fb;
      p.mid  = (idx == a.fb) && cln_nz;
      p.tail = ({1'b0, idx} == a.fb2p1) && cln_nz;
      return p;
   endfunction

   function automatic btm_part_type axis_sel(input btm_pre_type p,
                                             input btm_axis_type a);
      btm_part_type r;
      logic t4_nz;
      t4_nz = (a.t4 != '0);
      if (p.lt) begin
         r.host = t4_nz ? (p.idx >> 1) : p.idx;
         if (p.idx[0] && t4_nz) begin
            r.size = a.t4;
            r.off  = a.t1;
         end else begin
            r.size = a.t1;
            r.off  = '0;
         end
      end else if (p.mid) begin
         // middle cleanup tile
         r.host = {1'b0, a.fa};
         r.size = a.cln;
         r.off  = p.idx[0] ? a.t1 : '0;
      end else if (p.tail) begin
         // end cleanup tile
         r.host = a.last;
         r.size = a.cln;
         r.off  = a.fb[0] ? '0 : a.t4;
      end else begin
         r.host = t4_nz ? (p.i2 >> 1) : p.i2;
         if (a.fb_gt) begin
            r.size = p.i2[0] ? a.t1 : a.t4;
         end else begin
            r.size = (p.i2[0] && t4_nz) ? a.t4 : a.t1;
         end
         r.off = (p.i2[0] ^ a.fb[0]) ? '0 : a.t4;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [ORDER_W-1:0] matrix_order_ff;
   logic [SIZE_W-1:0]  tile_height_ff;
   logic [SIZE_W-1:0]  tile_width_ff;
   logic [SIZE_W-1:0]  mb_eff;
   logic [SIZE_W-1:0]  nb_eff;
   logic               csr_write;
   logic               csr_hit;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_hit    = csr_write && (csr_paddr[3:2] == REG_MATRIX_ORDER ||
                                     csr_paddr[3:2] == REG_TILE_HEIGHT ||
                                     csr_paddr[3:2] == REG_TILE_WIDTH);
   assign mb_eff = (tile_height_ff == '0) ? SIZE_W'(1) : tile_height_ff;
   assign nb_eff = (tile_width_ff == '0) ? SIZE_W'(1) : tile_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_order_ff <= ORDER_W'(1);
         tile_height_ff  <= SIZE_W'(1);
         tile_width_ff   <= SIZE_W'(1);
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_MATRIX_ORDER: matrix_order_ff <= csr_pwdata[ORDER_W-1:0];
            REG_TILE_HEIGHT:  tile_height_ff  <= csr_pwdata[SIZE_W-1:0];
            REG_TILE_WIDTH:   tile_width_ff   <= csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_MATRIX_ORDER: csr_prdata = CSR_DATA_W'(matrix_order_ff);
         REG_TILE_HEIGHT:  csr_prdata = CSR_DATA_W'(tile_height_ff);
         REG_TILE_WIDTH:   csr_prdata = CSR_DATA_W'(tile_width_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- dividers
   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [HALF_W-1:0] quo_h_ff, quo_h_in, quo_w_ff, quo_w_in;
   logic [SIZE_W-1:0] rem_h_ff, rem_h_in, rem_w_ff, rem_w_in;
   logic [SIZE_W:0]   sh_h, sh_w;
   logic              ge_h, ge_w;
   btm_axis_type      row_cfg_ff, row_cfg_in, col_cfg_ff, col_cfg_in;
   logic [SIZE_W-1:0] row_cln;

   assign sh_h = {rem_h_ff, quo_h_ff[HALF_W-1]};
   assign sh_w = {rem_w_ff, quo_w_ff[HALF_W-1]};
   assign ge_h = sh_h >= {1'b0, mb_eff};
   assign ge_w = sh_w >= {1'b0, nb_eff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      quo_h_in = quo_h_ff;
      quo_w_in = quo_w_ff;
      rem_h_in = rem_h_ff;
      rem_w_in = rem_w_ff;
      unique case (state_ff)
         ST_LOAD: begin
            quo_h_in = matrix_order_ff[ORDER_W-1:1];
            quo_w_in = matrix_order_ff[ORDER_W-1:1];
            rem_h_in = '0;
            rem_w_in = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // one quotient bit per cycle on each lane
            rem_h_in = ge_h ? SIZE_W'(sh_h - {1'b0, mb_eff}) : sh_h[SIZE_W-1:0];
            rem_w_in = ge_w ? SIZE_W'(sh_w - {1'b0, nb_eff}) : sh_w[SIZE_W-1:0];
            quo_h_in = {quo_h_ff[HALF_W-2:0], ge_h};
            quo_w_in = {quo_w_ff[HALF_W-2:0], ge_w};
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) state_in = ST_FIN;
         end
         ST_FIN:   state_in = ST_READY;
         ST_READY: state_in = ST_READY;
         default:  state_in = ST_LOAD;
      endcase
      if (csr_hit) state_in = ST_LOAD;
   end

   // the column cleanup width is the row-derived cleanup height
   assign row_cln    = cleanup(rem_h_ff, mb_eff - rem_h_ff);
   assign row_cfg_in = make_axis(mb_eff, rem_h_ff, quo_h_ff, row_cln, rem_h_ff,
                                 matrix_order_ff[0]);
   assign col_cfg_in = make_axis(nb_eff, rem_w_ff, quo_w_ff, row_cln, row_cln,
                                 matrix_order_ff[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      quo_h_ff <= quo_h_in;
      quo_w_ff <= quo_w_in;
      rem_h_ff <= rem_h_in;
      rem_w_ff <= rem_w_in;
      if (state_ff == ST_FIN) begin
         row_cfg_ff <= row_cfg_in;
         col_cfg_ff <= col_cfg_in;
      end
   end

   // ---------------------------------------------------------------- pipeline
   logic                adv;
   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   btm_pre_type         s1_row_ff, s1_row_in, s1_col_ff, s1_col_in;
   btm_part_type        s2_row_ff, s2_row_in, s2_col_ff, s2_col_in;
   logic [PROD_W-1:0]   s3_prod_ff, s3_prod_in;
   logic [SIZE_W-1:0]   s3_offw_ff;
   logic [ORDER_W-1:0]  s3_host_row_ff, s3_host_col_ff;
   logic [SIZE_W-1:0]   s3_height_ff, s3_width_ff;
   btm_rsp_type         rsp_data_ff, rsp_data_in;

   // whole pipeline moves unless the output register holds an untaken result
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && (state_ff == ST_READY);

   assign s1_row_in  = axis_pre(req_data.row_index, row_cfg_ff);
   assign s1_col_in  = axis_pre(req_data.col_index, col_cfg_ff);
   assign s2_row_in  = axis_sel(s1_row_ff, row_cfg_ff);
   assign s2_col_in  = axis_sel(s1_col_ff, col_cfg_ff);
   assign s3_prod_in = PROD_W'(s2_row_ff.off) * PROD_W'(row_cfg_ff.tsz);

   always_comb begin
      rsp_data_in.host_row    = s3_host_row_ff;
      rsp_data_in.host_col    = s3_host_col_ff;
      rsp_data_in.part_height = s3_height_ff;
      rsp_data_in.part_width  = s3_width_ff;
      rsp_data_in.elem_offset = OFFSET_W'(s3_prod_ff + PROD_W'(s3_offw_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_valid && req_ready;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_row_ff      <= s1_row_in;
         s1_col_ff      <= s1_col_in;
         s2_row_ff      <= s2_row_in;
         s2_col_ff      <= s2_col_in;
         s3_prod_ff     <= s3_prod_in;
         s3_offw_ff     <= s2_col_ff.off;
         s3_host_row_ff <= s2_row_ff.host;
         s3_host_col_ff <= s2_col_ff.host;
         s3_height_ff   <= s2_row_ff.size;
         s3_width_ff    <= s2_col_ff.size;
         rsp_data_ff    <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   a_write_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> !req_ready)
      else $error("request taken right after a register write");

   a_divider_remainder: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN |-> (rem_h_ff < mb_eff) && (rem_w_ff < nb_eff))
      else $error("divider remainder not below divisor");

   a_result_from_pipeline: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s3_valid_ff))
      else $error("result appeared without a request in the last stage");

endmodule
